// ----- hdl/logistic_map_xor_stream_cipher_top_macros.svh -----
// Assertion helpers used by lmx_seq
`ifndef LOGISTIC_MAP_XOR_STREAM_CIPHER_TOP_MACROS_SVH
`define LOGISTIC_MAP_XOR_STREAM_CIPHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lmx_pkg.sv -----
// ----------------------------------------------------------------------------
// lmx_pkg
// Types and constants of the logistic-map XOR stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package lmx_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OPA_W     = WORD_W + 1;
  localparam int unsigned PROD_W    = OPA_W + WORD_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] GAIN_RESET = 32'hFF5C_28F6;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'h8000_0000;
  localparam logic [OPA_W-1:0]  KEY_SCALE  = 33'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 1'b0,
    CFG_SEED = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_G,
    ST_MUL_K,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_PROD,   // x * (1 - x)
    OP_GAIN,   // r * p
    OP_KEY     // x' * 255
  } mul_op_t;

  typedef struct packed {
    mul_op_t op;
    logic    mul_en;
    logic    load_x;    // x <= x' from the gain product
    logic    load_out;  // result register takes the key
    logic    in_ready;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lmx_in_if.sv -----
// ----------------------------------------------------------------------------
// lmx_in_if
// Input channel: one data byte and its start-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmx_in_if;
  logic                          valid;
  logic                          ready;
  logic [lmx_pkg::DATA_W-1:0]    data_byte;
  logic                          start_of_message;

  modport source (output valid, output data_byte, output start_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input start_of_message,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/lmx_out_if.sv -----
// ----------------------------------------------------------------------------
// lmx_out_if
// Result channel: transformed byte and the key byte used.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmx_out_if;
  logic                          valid;
  logic                          ready;
  logic [lmx_pkg::DATA_W-1:0]    out_byte;
  logic [lmx_pkg::DATA_W-1:0]    key_byte;

  modport source (output valid, output out_byte, output key_byte, input ready);
  modport sink   (input valid, input out_byte, input key_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/logistic_map_xor_stream_cipher_top.sv -----
// ----------------------------------------------------------------------------
// logistic_map_xor_stream_cipher_top
// Logistic-map chaotic stream cipher: each byte XORed with a key from the map.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready channel carrying data_byte and start_of_message.
//            A transaction with start_of_message set reloads the map value
//            from the seed register before the map is advanced.
//   out_ch : valid/ready channel carrying out_byte (data XOR key) and the
//            key_byte used. One result per input transaction, in order.
//   cfg_*  : write-only registers, gain (index 0, Q2.30) and seed (index 1,
//            Q0.32). Write only while no byte is in flight.
//   Sequence: an accepted byte steps through ST_MUL_P, ST_MUL_G and ST_MUL_K;
//   a new byte is taken only in ST_IDLE or ST_DONE, as the single shared
//   multiplier forms x*(1-x), r*p and x*255 in turn.
//   Reset: gain = 3.99, seed = map value = 0.5, both channels empty.
//   Stall: a finished result waits in ST_DONE for the output slot; the next input
//   transaction is taken in the cycle the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module logistic_map_xor_stream_cipher_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lmx_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [lmx_pkg::WORD_W-1:0]        cfg_wdata,
  lmx_in_if.sink                                 in_ch,
  lmx_out_if.source                              out_ch
);

  localparam int unsigned W = lmx_pkg::WORD_W;

  lmx_pkg::ctrl_t              ctrl;
  logic [W-1:0]                gain_r;
  logic [W-1:0]                seed_r;
  logic [W-1:0]                x_r;
  logic [W-1:0]                x_nxt;
  logic [lmx_pkg::DATA_W-1:0]  data_r;
  logic [lmx_pkg::DATA_W-1:0]  out_byte_r;
  logic [lmx_pkg::DATA_W-1:0]  key_byte_r;
  logic                        out_valid_r;
  logic                        out_free;
  logic                        accept;
  logic [lmx_pkg::OPA_W-1:0]   op_a;
  logic [W-1:0]                op_b;
  logic [lmx_pkg::PROD_W-1:0]  prod_r;
  logic [W-1:0]                x_new;
  logic [lmx_pkg::DATA_W-1:0]  key;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && ctrl.in_ready;
  assign in_ch.ready = ctrl.in_ready;

  lmx_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // r*p in Q2.30 x Q0.32, shifted back to Q0.32; saturate at all ones
  assign x_new = (|prod_r[lmx_pkg::PROD_W-1:2*W-2]) ? '1 : prod_r[2*W-3:W-2];
  assign key   = prod_r[W+lmx_pkg::DATA_W-1:W];

  always_comb begin
    op_a = {1'b0, x_r};
    op_b = x_r;
    case (ctrl.op)
      lmx_pkg::OP_PROD: begin
        // 1 - x as a 33-bit value, 1.0 when x is zero
        op_a = {1'b1, {W{1'b0}}} - {1'b0, x_r};
        op_b = x_r;
      end
      lmx_pkg::OP_GAIN: begin
        op_a = {1'b0, gain_r};
        op_b = prod_r[2*W-1:W];
      end
      lmx_pkg::OP_KEY: begin
        op_a = lmx_pkg::KEY_SCALE;
        op_b = x_new;
      end
      default: begin
        op_a = {1'b0, x_r};
      end
    endcase
  end

  lmx_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_comb begin
    x_nxt = x_r;
    if (ctrl.load_x) begin
      x_nxt = x_new;
    end else if (accept && in_ch.start_of_message) begin
      x_nxt = seed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= lmx_pkg::GAIN_RESET;
      seed_r      <= lmx_pkg::SEED_RESET;
      x_r         <= lmx_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      x_r <= x_nxt;
      if (cfg_we) begin
        case (lmx_pkg::cfg_idx_t'(cfg_idx))
          lmx_pkg::CFG_GAIN: gain_r <= cfg_wdata;
          lmx_pkg::CFG_SEED: seed_r <= cfg_wdata;
          default:           gain_r <= gain_r;
        endcase
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_ch.data_byte;
    end
    if (ctrl.load_out) begin
      out_byte_r <= data_r ^ key;
      key_byte_r <= key;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.key_byte = key_byte_r;

endmodule

`default_nettype wire

// ----- hdl/lmx_mul.sv -----
// ----------------------------------------------------------------------------
// lmx_mul
// Shared 33x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module lmx_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [lmx_pkg::OPA_W-1:0]     op_a,
  input  wire logic [lmx_pkg::WORD_W-1:0]    op_b,
  output      logic [lmx_pkg::PROD_W-1:0]    prod_r
);

  logic [lmx_pkg::PROD_W-1:0] prod_nxt;

  always_comb begin
    prod_nxt = lmx_pkg::PROD_W'(op_a) * lmx_pkg::PROD_W'(op_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lmx_seq.sv -----
// ----------------------------------------------------------------------------
// lmx_seq
// Sequencer: steps the shared multiplier through the three products of a byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "logistic_map_xor_stream_cipher_top_macros.svh"

module lmx_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_free,
  output      lmx_pkg::ctrl_t  ctrl
);

  lmx_pkg::state_t state_r;
  lmx_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_valid && ctrl.in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmx_pkg::ST_IDLE:  if (accept) state_nxt = lmx_pkg::ST_MUL_P;
      lmx_pkg::ST_MUL_P: state_nxt = lmx_pkg::ST_MUL_G;
      lmx_pkg::ST_MUL_G: state_nxt = lmx_pkg::ST_MUL_K;
      lmx_pkg::ST_MUL_K: state_nxt = lmx_pkg::ST_DONE;
      lmx_pkg::ST_DONE: begin
        if (accept) begin
          state_nxt = lmx_pkg::ST_MUL_P;
        end else if (out_free) begin
          state_nxt = lmx_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = lmx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.op       = lmx_pkg::OP_PROD;
    case (state_r)
      lmx_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
      end
      lmx_pkg::ST_MUL_P: begin
        ctrl.op     = lmx_pkg::OP_PROD;
        ctrl.mul_en = 1'b1;
      end
      lmx_pkg::ST_MUL_G: begin
        ctrl.op     = lmx_pkg::OP_GAIN;
        ctrl.mul_en = 1'b1;
      end
      lmx_pkg::ST_MUL_K: begin
        ctrl.op     = lmx_pkg::OP_KEY;
        ctrl.mul_en = 1'b1;
        ctrl.load_x = 1'b1;
      end
      lmx_pkg::ST_DONE: begin
        // result leaves as soon as the output slot frees; next byte may enter then
        ctrl.load_out = out_free;
        ctrl.in_ready = out_free;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LMX_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_r == lmx_pkg::ST_MUL_P, "accept did not start a map step")
  `LMX_ASSERT_NXT(a_p_then_g, clk, rst_n, state_r == lmx_pkg::ST_MUL_P, state_r == lmx_pkg::ST_MUL_G, "gain product skipped")
  `LMX_ASSERT_NXT(a_g_then_k, clk, rst_n, state_r == lmx_pkg::ST_MUL_G, state_r == lmx_pkg::ST_MUL_K, "key product skipped")
  `LMX_ASSERT_IMP(a_ready_not_busy, clk, rst_n, ctrl.in_ready, !ctrl.mul_en, "input taken while multiplier busy")

endmodule

`default_nettype wire

// ----- sim/logistic_map_xor_stream_cipher_top_tb.sv -----
// ----------------------------------------------------------------------------
// logistic_map_xor_stream_cipher_top_tb
// Self-checking bench for the logistic-map XOR stream cipher. A directed
// set covers reset defaults, map collapse and the largest key, then random
// messages run under several gain/seed settings with random idling on both
// channels. Each result is compared with a local model of the map.
// ----------------------------------------------------------------------------
module logistic_map_xor_stream_cipher_top_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TIMEOUT_CYCLES = 150000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 82;
  localparam int HOLD_CYCLES    = 250;
  localparam int HOLD_AT_A      = 140;
  localparam int HOLD_AT_B      = 460;

  typedef struct {
    logic [lmx_pkg::DATA_W-1:0] data;
    logic                       som;
    int unsigned                gap;
    logic                       drain;   // wait for every result before offering
  } byte_item_t;

  typedef struct {
    logic [lmx_pkg::DATA_W-1:0] out_byte;
    logic [lmx_pkg::DATA_W-1:0] key_byte;
  } cipher_res_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lmx_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lmx_pkg::WORD_W-1:0]    cfg_wdata;

  lmx_in_if  in_ch ();
  lmx_out_if out_ch ();

  logistic_map_xor_stream_cipher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // local copy of the cipher state
  logic [lmx_pkg::WORD_W-1:0] gain_r = lmx_pkg::GAIN_RESET;
  logic [lmx_pkg::WORD_W-1:0] seed_r = lmx_pkg::SEED_RESET;
  logic [lmx_pkg::WORD_W-1:0] map_r  = lmx_pkg::SEED_RESET;

  byte_item_t  plain_q[$];
  cipher_res_t cipher_q[$];
  int          issued_cnt   = 0;
  int          accepted_cnt = 0;
  int          received_cnt = 0;
  int          mismatch_cnt = 0;
  int          tx_gap_left  = -1;
  int          rx_wait      = 0;
  logic        rx_idle      = 1'b0;

  function automatic logic [lmx_pkg::WORD_W-1:0] chaos_step(
      input logic [lmx_pkg::WORD_W-1:0] x,
      input logic [lmx_pkg::WORD_W-1:0] r);
    logic [32:0] one_minus;
    logic [64:0] prod;
    logic [31:0] p;
    logic [63:0] scaled;
    logic [33:0] nx;
    one_minus = 33'h1_0000_0000 - {1'b0, x};
    prod      = {33'd0, x} * {32'd0, one_minus};
    p         = prod[63:32];
    scaled    = {32'd0, r} * {32'd0, p};
    nx        = scaled[63:30];
    return (nx > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : nx[31:0];
  endfunction

  // advances the map for one byte and returns the cipher output
  function automatic cipher_res_t cipher_step(input logic [lmx_pkg::DATA_W-1:0] data,
                                              input logic som);
    cipher_res_t res;
    logic [63:0] k;
    if (som) map_r = seed_r;
    map_r        = chaos_step(map_r, gain_r);
    k            = {32'd0, map_r} * 64'd255;
    res.key_byte = k[39:32];
    res.out_byte = data ^ k[39:32];
    return res;
  endfunction

  task automatic log_fail(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // sender
  always @(posedge clk) begin
    byte_item_t nxt;
    logic       offer;
    if (!rst_n) begin
      in_ch.valid            <= 1'b0;
      in_ch.data_byte        <= '0;
      in_ch.start_of_message <= 1'b0;
      tx_gap_left = -1;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        cipher_q = {cipher_q, cipher_step(in_ch.data_byte, in_ch.start_of_message)};
        accepted_cnt++;
        offer = 1'b0;
      end
      if (!offer && plain_q.size() != 0) begin
        if (tx_gap_left < 0) tx_gap_left = plain_q[0].gap;
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (!(plain_q[0].drain && cipher_q.size() != 0)) begin
          nxt = plain_q.pop_front();
          in_ch.data_byte        <= nxt.data;
          in_ch.start_of_message <= nxt.som;
          offer       = 1'b1;
          tx_gap_left = -1;
        end
      end
      in_ch.valid <= offer;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    cipher_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        received_cnt++;
        if (cipher_q.size() == 0) begin
          log_fail($sformatf("result %0d: out=%02h key=%02h with no transaction pending",
                             received_cnt, out_ch.out_byte, out_ch.key_byte));
        end else begin
          want = cipher_q.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.key_byte !== want.key_byte)
            log_fail($sformatf("result %0d: out=%02h key=%02h, expected out=%02h key=%02h",
                               received_cnt, out_ch.out_byte, out_ch.key_byte,
                               want.out_byte, want.key_byte));
        end
        rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
        // long hold-off so the block backs up and stalls its input
        if (received_cnt == HOLD_AT_A || received_cnt == HOLD_AT_B) rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [lmx_pkg::DATA_W-1:0] data, input logic som,
                            input int unsigned gap, input logic drain);
    byte_item_t it;
    it.data  = data;
    it.som   = som;
    it.gap   = gap;
    it.drain = drain;
    plain_q = {plain_q, it};
    issued_cnt++;
  endtask

  task automatic write_reg(input lmx_pkg::cfg_idx_t idx,
                           input logic [lmx_pkg::WORD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lmx_pkg::CFG_GAIN: gain_r = val;
      lmx_pkg::CFG_SEED: seed_r = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != issued_cnt || cipher_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int   cnt;
    int   len;
    logic tx_idle;
    logic som;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, map running from 0.5 without a start mark first
    @(negedge clk);
    queue_byte(8'h00, 1'b0, 0, 1'b0);
    queue_byte(8'hFF, 1'b0, 0, 1'b0);
    queue_byte(8'h80, 1'b0, 0, 1'b0);
    queue_byte(8'h01, 1'b1, 0, 1'b0);
    queue_byte(8'hFE, 1'b0, 0, 1'b0);
    queue_byte(8'h55, 1'b0, 0, 1'b0);
    queue_byte(8'hAA, 1'b1, 0, 1'b0);
    wait_idle();
    // zero gain: map collapses, key is zero
    write_reg(lmx_pkg::CFG_GAIN, 32'h0000_0000);
    @(negedge clk);
    queue_byte(8'h3C, 1'b1, 0, 1'b0);
    queue_byte(8'hC3, 1'b0, 0, 1'b0);
    wait_idle();
    // zero seed stays zero even at full gain
    write_reg(lmx_pkg::CFG_GAIN, 32'hFFFF_FFFF);
    write_reg(lmx_pkg::CFG_SEED, 32'h0000_0000);
    @(negedge clk);
    queue_byte(8'h12, 1'b1, 0, 1'b0);
    queue_byte(8'hED, 1'b0, 0, 1'b0);
    wait_idle();
    // seed at all ones: 1 - x is one lsb, map falls to zero
    write_reg(lmx_pkg::CFG_SEED, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_byte(8'h77, 1'b1, 0, 1'b0);
    queue_byte(8'h88, 1'b0, 0, 1'b0);
    queue_byte(8'h99, 1'b0, 0, 1'b0);
    wait_idle();
    // full gain from 0.5 gives the largest map value and key
    write_reg(lmx_pkg::CFG_SEED, 32'h8000_0000);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1, 0, 1'b0);
    queue_byte(8'h00, 1'b0, 0, 1'b0);
    wait_idle();
    write_reg(lmx_pkg::CFG_GAIN, 32'h4000_0000);
    write_reg(lmx_pkg::CFG_SEED, 32'h0000_0001);
    @(negedge clk);
    queue_byte(8'h0F, 1'b1, 0, 1'b0);
    queue_byte(8'hF0, 1'b0, 0, 1'b0);
    wait_idle();
    write_reg(lmx_pkg::CFG_GAIN, lmx_pkg::GAIN_RESET);
    write_reg(lmx_pkg::CFG_SEED, 32'h7FFF_FFFF);
    @(negedge clk);
    queue_byte(8'h69, 1'b1, 0, 1'b0);
    queue_byte(8'h96, 1'b0, 0, 1'b0);
    queue_byte(8'h5A, 1'b0, 0, 1'b0);
    wait_idle();

    // random messages, mostly well formed, under changing settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(lmx_pkg::CFG_GAIN, $urandom_range(32'hE000_0000, 32'hFFFF_FFFF));
          write_reg(lmx_pkg::CFG_SEED, $urandom());
        end
        1: begin
          write_reg(lmx_pkg::CFG_GAIN, $urandom());
          write_reg(lmx_pkg::CFG_SEED, $urandom());
        end
        2: begin
          write_reg(lmx_pkg::CFG_GAIN, 32'hFFFF_FFFF);
          write_reg(lmx_pkg::CFG_SEED, $urandom());
        end
        default: begin
          write_reg(lmx_pkg::CFG_GAIN, $urandom_range(32'hC000_0000, 32'hFFFF_FFFF));
          write_reg(lmx_pkg::CFG_SEED,
                    $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFE);
        end
      endcase
      tx_idle = ph[0];
      rx_idle = ph[1];
      @(negedge clk);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len && cnt < PHASE_ITEMS; i++) begin
          // a missing start mark or a stray one in mid-message now and then
          som = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
          queue_byte(8'($urandom_range(0, 255)), som,
                     tx_idle ? $urandom_range(0, 8) : 0,
                     cnt == PHASE_ITEMS / 2);
          cnt++;
        end
      end
      wait_idle();
    end

    if (cipher_q.size() != 0)
      log_fail($sformatf("%0d results never arrived", cipher_q.size()));
    if (mismatch_cnt == 0) begin
      $display("logistic_map_xor_stream_cipher_top_tb: clean");
    end else begin
      $display("logistic_map_xor_stream_cipher_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("logistic_map_xor_stream_cipher_top_tb: errors");
    $finish;
  end

endmodule

// ----- logistic_map_xor_stream_cipher_top.f -----
+incdir+hdl
hdl/lmx_pkg.sv
hdl/lmx_in_if.sv
hdl/lmx_out_if.sv
hdl/lmx_mul.sv
hdl/lmx_seq.sv
hdl/logistic_map_xor_stream_cipher_top.sv
sim/logistic_map_xor_stream_cipher_top_tb.sv
